FILE: src/rcpsm_pkg.sv
// Shared types, constants and helpers for the RC pulse capture and stick mapper.
// No dependencies; every other file imports this package.
package rcpsm_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int TIMEOUT_MS   = 500;

    localparam int CH_W     = 3;
    localparam int FN_W     = 3;
    localparam int WIDTH_W  = 16;
    localparam int VALUE_W  = 24;
    localparam int TIME_W   = 32;
    localparam int SETUP_W  = 36;
    localparam int RANGE_W  = 48;
    localparam int PDATA_W  = 64;

    localparam int NUM_REGS     = NUM_CHANNELS + 2;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);
    localparam int PADDR_W      = REG_IDX_W + 3;
    localparam int REG_THROTTLE = NUM_CHANNELS;
    localparam int REG_ATTITUDE = NUM_CHANNELS + 1;

    localparam int FIFO_DEPTH = 2;
    localparam int QUOT_W     = 25;

    localparam logic [FN_W-1:0] FN_THROTTLE = 3'd0;
    localparam logic [FN_W-1:0] FN_ROLL     = 3'd1;
    localparam logic [FN_W-1:0] FN_PITCH    = 3'd2;
    localparam logic [FN_W-1:0] FN_YAW      = 3'd3;

    localparam logic [WIDTH_W-1:0] DEAD_LO        = 16'd1490;
    localparam logic [WIDTH_W-1:0] DEAD_HI        = 16'd1510;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH    = 16'd1500;
    localparam logic [WIDTH_W-1:0] THROTTLE_FLOOR = 16'd1125;
    localparam logic [WIDTH_W-1:0] WMIN_RESET     = 16'd1000;
    localparam logic [WIDTH_W-1:0] WMAX_RESET     = 16'd2000;

    localparam logic signed [24:0] AUX_MAX_Q8 = 25'sd25600;
    localparam logic signed [24:0] AUX_MIN_Q8 = 25'sd0;

    localparam logic [RANGE_W-1:0] THROTTLE_RESET = 48'd429496729600;
    localparam logic [RANGE_W-1:0] ATTITUDE_RESET = 48'd128849018880;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0][SETUP_W-1:0] setup;
        logic [RANGE_W-1:0]                   throttle;
        logic [RANGE_W-1:0]                   attitude;
    } cfg_t;

    typedef struct packed {
        logic                                 timed_out;
        logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] widths;
    } rd_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_ctrl_t;

    function automatic logic [SETUP_W-1:0] setup_reset(input int idx);
        return {1'b0, FN_W'(idx), WMAX_RESET, WMIN_RESET};
    endfunction

endpackage

FILE: src/rcpsm_in_if.sv
// Input channel interface: pin edge events and read requests.
// Depends on rcpsm_pkg.
interface rcpsm_in_if import rcpsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CH_W-1:0]   channel;
    logic              pin_level;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, req_type, channel, pin_level, now_us, now_ms, input ready);
    modport sink (input valid, req_type, channel, pin_level, now_us, now_ms, output ready);
endinterface

FILE: src/rcpsm_out_if.sv
// Output channel interface: one mapped stick result per channel.
// Depends on rcpsm_pkg.
interface rcpsm_out_if import rcpsm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CH_W-1:0]           source_channel;
    logic [FN_W-1:0]           function_code;
    logic signed [VALUE_W-1:0] stick_value;
    logic [WIDTH_W-1:0]        raw_width;
    logic                      disarm;
    logic                      last_of_run;

    modport source (output valid, source_channel, function_code, stick_value, raw_width,
                    disarm, last_of_run, input ready);
    modport sink (input valid, source_channel, function_code, stick_value, raw_width,
                  disarm, last_of_run, output ready);
endinterface

FILE: src/rcpsm_cfg.sv
// APB-style configuration register bank: channel setups and output ranges.
// Depends on rcpsm_pkg.
module rcpsm_cfg import rcpsm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [NUM_CHANNELS-1:0][SETUP_W-1:0] setup_reg;
    logic [RANGE_W-1:0]                   throttle_reg;
    logic [RANGE_W-1:0]                   attitude_reg;
    logic [REG_IDX_W-1:0]                 idx;
    logic                                 wr;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:3];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                setup_reg[i] <= setup_reset(i);
            end
            throttle_reg <= THROTTLE_RESET;
            attitude_reg <= ATTITUDE_RESET;
        end
        else if (wr)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (idx == REG_IDX_W'(i))
                begin
                    setup_reg[i] <= pwdata[SETUP_W-1:0];
                end
            end
            if (idx == REG_IDX_W'(REG_THROTTLE))
            begin
                throttle_reg <= pwdata[RANGE_W-1:0];
            end
            if (idx == REG_IDX_W'(REG_ATTITUDE))
            begin
                attitude_reg <= pwdata[RANGE_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (idx == REG_IDX_W'(i))
            begin
                prdata = PDATA_W'(setup_reg[i]);
            end
        end
        if (idx == REG_IDX_W'(REG_THROTTLE))
        begin
            prdata = PDATA_W'(throttle_reg);
        end
        if (idx == REG_IDX_W'(REG_ATTITUDE))
        begin
            prdata = PDATA_W'(attitude_reg);
        end
    end

    assign cfg.setup    = setup_reg;
    assign cfg.throttle = throttle_reg;
    assign cfg.attitude = attitude_reg;

endmodule

FILE: src/rcpsm_front.sv
// Front end: accepts requests, captures pulse widths from pin edges and
// queues read jobs with a width snapshot and the timeout flag. Depends on rcpsm_pkg.
module rcpsm_front import rcpsm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rcpsm_in_if.sink   inbound,
    input  q_ctrl_t    q_stat,
    output logic       q_push,
    output rd_job_t    q_job
);

    logic [NUM_CHANNELS-1:0][TIME_W-1:0]  start_reg;
    logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] width_reg;
    logic [TIME_W-1:0]                    act_reg;
    logic [TIME_W-1:0]                    start_sel;
    logic [TIME_W-1:0]                    elapsed_us;
    logic [TIME_W-1:0]                    idle_ms;
    logic                                 accept;
    logic                                 pin_evt;

    assign inbound.ready = !q_stat.full;
    assign accept        = inbound.valid && inbound.ready;
    assign pin_evt       = accept && !inbound.req_type
                           && (inbound.channel < CH_W'(NUM_CHANNELS));

    always_comb
    begin
        start_sel = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (inbound.channel == CH_W'(i))
            begin
                start_sel = start_reg[i];
            end
        end
    end

    assign elapsed_us = inbound.now_us - start_sel;
    assign idle_ms    = inbound.now_ms - act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                start_reg[i] <= '0;
                width_reg[i] <= RESET_WIDTH;
            end
            act_reg <= '0;
        end
        else if (pin_evt)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (inbound.channel == CH_W'(i))
                begin
                    if (inbound.pin_level)
                    begin
                        start_reg[i] <= inbound.now_us;
                    end
                    else
                    begin
                        width_reg[i] <= elapsed_us[WIDTH_W-1:0];
                    end
                end
            end
            act_reg <= inbound.now_ms;
        end
    end

    assign q_push          = accept && inbound.req_type;
    assign q_job.timed_out = idle_ms > TIME_W'(TIMEOUT_MS);
    assign q_job.widths    = width_reg;

endmodule

FILE: src/rcpsm_fifo.sv
// Short job queue between the front end and the mapping back end.
// Depends on rcpsm_pkg.
module rcpsm_fifo import rcpsm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  rd_job_t push_job,
    input  logic    pop,
    output rd_job_t head_job,
    output q_ctrl_t stat
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    rd_job_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = count_reg == CNT_W'(FIFO_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/rcpsm_back.sv
// Back end: maps each channel of a queued read job to a Q15.8 stick value
// with a bit-serial divider and drives the output register. Depends on rcpsm_pkg.
module rcpsm_back import rcpsm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  rd_job_t     head_job,
    input  q_ctrl_t     q_stat,
    output logic        q_pop,
    rcpsm_out_if.source outbound
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int QCNT_W = $clog2(QUOT_W);
    localparam int NUM_W  = 44;
    localparam logic signed [26:0] SAT_HI = 27'sd8388607;
    localparam logic signed [26:0] SAT_LO = -27'sd8388608;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    rd_job_t                job_reg;
    logic [CH_W-1:0]        chan_reg;
    logic signed [41:0]     p1_reg;
    logic signed [42:0]     p2_reg;
    logic signed [24:0]     olo_reg;
    logic                   zero_reg;
    logic                   eqlim_reg;
    logic                   dneg_reg;
    logic                   inv_reg;
    logic                   neg_reg;
    logic [WIDTH_W-1:0]     dabs_reg;
    logic [WIDTH_W-1:0]     rem_reg;
    logic [QUOT_W-1:0]      qsh_reg;
    logic [QCNT_W-1:0]      cnt_reg;

    logic                      out_valid_reg;
    logic [CH_W-1:0]           out_chan_reg;
    logic [FN_W-1:0]           out_fn_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [WIDTH_W-1:0]        out_width_reg;
    logic                      out_disarm_reg;
    logic                      out_last_reg;

    logic [SETUP_W-1:0]  setup_sel;
    logic [WIDTH_W-1:0]  w_sel;
    logic [WIDTH_W-1:0]  wmin;
    logic [WIDTH_W-1:0]  wmax;
    logic [WIDTH_W-1:0]  wc;
    logic [FN_W-1:0]     fn;
    logic signed [24:0]  olo;
    logic signed [24:0]  ohi;
    logic signed [25:0]  span;
    logic signed [16:0]  d;
    logic signed [16:0]  nd;
    logic signed [16:0]  dw;
    logic signed [41:0]  prod1;
    logic signed [42:0]  prod2;
    logic                is_att;
    logic                in_dead;
    logic                below_floor;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    num_adj;
    logic [NUM_W-1:0]    mag;
    logic [WIDTH_W:0]    trial;
    logic [WIDTH_W+1:0]  diff;
    logic                ge;
    logic [26:0]         qv;
    logic signed [26:0]  base;
    logic signed [26:0]  val;
    logic signed [26:0]  sat;
    logic                last_chan;
    logic                out_load;

    always_comb
    begin
        setup_sel = '0;
        w_sel     = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (chan_reg == CH_W'(i))
            begin
                setup_sel = cfg.setup[i];
                w_sel     = job_reg.widths[i];
            end
        end
    end

    assign wmin = setup_sel[15:0];
    assign wmax = setup_sel[31:16];
    assign fn   = setup_sel[34:32];

    always_comb
    begin
        unique case (fn) inside
            FN_THROTTLE:
            begin
                olo = {cfg.throttle[23], cfg.throttle[23:0]};
                ohi = {cfg.throttle[47], cfg.throttle[47:24]};
            end
            FN_ROLL, FN_PITCH:
            begin
                ohi = {cfg.attitude[23], cfg.attitude[23:0]};
                olo = -ohi;
            end
            FN_YAW:
            begin
                ohi = {cfg.attitude[47], cfg.attitude[47:24]};
                olo = -ohi;
            end
            default:
            begin
                olo = AUX_MIN_Q8;
                ohi = AUX_MAX_Q8;
            end
        endcase
    end

    always_comb
    begin
        if (w_sel < wmin)
        begin
            wc = wmin;
        end
        else if (w_sel > wmax)
        begin
            wc = wmax;
        end
        else
        begin
            wc = w_sel;
        end
    end

    assign d     = {1'b0, wmax} - {1'b0, wmin};
    assign nd    = -d;
    assign dw    = {1'b0, wc} - {1'b0, wmin};
    assign span  = {ohi[24], ohi} - {olo[24], olo};
    assign prod1 = olo * d;
    assign prod2 = dw * span;

    assign is_att      = (fn == FN_ROLL) || (fn == FN_PITCH) || (fn == FN_YAW);
    assign in_dead     = is_att && (w_sel >= DEAD_LO) && (w_sel <= DEAD_HI);
    assign below_floor = (fn == FN_THROTTLE) && (w_sel < THROTTLE_FLOOR);

    assign num     = {p1_reg[41], p1_reg[41], p1_reg} + {p2_reg[42], p2_reg};
    assign num_adj = dneg_reg ? -num : num;
    assign mag     = num_adj[NUM_W-1] ? -num_adj : num_adj;

    assign trial = {rem_reg, qsh_reg[QUOT_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dabs_reg};
    assign ge    = !diff[WIDTH_W+1];

    assign qv = {2'b00, qsh_reg};

    always_comb
    begin
        if (zero_reg)
        begin
            base = '0;
        end
        else if (eqlim_reg)
        begin
            base = {olo_reg[24], olo_reg[24], olo_reg};
        end
        else
        begin
            base = neg_reg ? -qv : qv;
        end
        val = inv_reg ? -base : base;
        if (val > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (val < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = val;
        end
    end

    assign last_chan = chan_reg == CH_W'(NUM_CHANNELS - 1);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || outbound.ready);
    assign q_pop     = (state_reg == ST_IDLE) && !q_stat.empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = (zero_reg || eqlim_reg) ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == QCNT_W'(QUOT_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = last_chan ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                chan_reg <= '0;
            end
            else if (out_load && !last_chan)
            begin
                chan_reg <= chan_reg + 1'b1;
            end
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (outbound.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head_job;
        end
        if (state_reg == ST_MUL)
        begin
            p1_reg    <= prod1;
            p2_reg    <= prod2;
            olo_reg   <= olo;
            zero_reg  <= job_reg.timed_out || in_dead || below_floor;
            eqlim_reg <= d == '0;
            dneg_reg  <= d[16];
            dabs_reg  <= d[16] ? nd[WIDTH_W-1:0] : d[WIDTH_W-1:0];
            inv_reg   <= setup_sel[35];
        end
        if (state_reg == ST_SUM)
        begin
            neg_reg <= num_adj[NUM_W-1];
            rem_reg <= mag[QUOT_W+WIDTH_W-1:QUOT_W];
            qsh_reg <= mag[QUOT_W-1:0];
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
            qsh_reg <= {qsh_reg[QUOT_W-2:0], ge};
        end
        if (out_load)
        begin
            out_chan_reg   <= chan_reg;
            out_fn_reg     <= fn;
            out_value_reg  <= sat[VALUE_W-1:0];
            out_width_reg  <= w_sel;
            out_disarm_reg <= job_reg.timed_out;
            out_last_reg   <= last_chan;
        end
    end

    assign outbound.valid          = out_valid_reg;
    assign outbound.source_channel = out_chan_reg;
    assign outbound.function_code  = out_fn_reg;
    assign outbound.stick_value    = out_value_reg;
    assign outbound.raw_width      = out_width_reg;
    assign outbound.disarm         = out_disarm_reg;
    assign outbound.last_of_run    = out_last_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < QCNT_W'(QUOT_W)))
        else $error("divider ran past its last quotient bit");

    a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_chan_reg == CH_W'(NUM_CHANNELS - 1)))
        else $error("end of run marked on a channel other than the last");

    a_disarm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_disarm_reg) |-> (out_value_reg == '0))
        else $error("timed-out result carries a nonzero stick value");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_chan) |=> (state_reg == ST_IDLE))
        else $error("back end did not return to idle after the last channel");

endmodule

FILE: src/rc_pulse_capture_and_stick_mapper.sv
// Top level of the RC pulse capture and stick mapper.
// Edge requests are accepted back to back while the job queue has room.
// A read request emits six results, one per channel, each through the multiply, sum, divide and emit
// states; the bit-serial divide is skipped for a zero result or an empty range, and emit waits on ready.
// rst_n clears the control state asynchronously: widths to 1500, stamps to zero, setups to defaults.
// Depends on rcpsm_pkg, the channel interfaces, rcpsm_cfg, rcpsm_front, rcpsm_fifo, rcpsm_back.
module rc_pulse_capture_and_stick_mapper import rcpsm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    rcpsm_in_if.sink           inbound,
    rcpsm_out_if.source        outbound,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t    cfg;
    rd_job_t push_job;
    rd_job_t head_job;
    q_ctrl_t q_stat;
    logic    q_push;
    logic    q_pop;

    rcpsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcpsm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .inbound (inbound),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    rcpsm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    rcpsm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head_job (head_job),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .outbound (outbound)
    );

endmodule
